/* hw/rtl/afam_pkg.sv */
// Constants, widths and helper functions for the accel/mag attitude pipeline.
package afam_pkg;

   localparam int CordicStages  = 16;
   localparam int AngleFracBits = 7;
   localparam int SampleBits    = 16;

   localparam int TableLen   = 24;
   localparam int StageCount = (CordicStages > TableLen) ? TableLen : CordicStages;

   localparam int SampleW = 16;   // raw field width
   localparam int AngleW  = 16;   // output angle width

   // mounting matrix, Q1.15
   localparam int MountC   = 23170;
   localparam int MountNeg = -32768;
   localparam int RotShift = 8;

   localparam int ProdW = 2 * SampleW + 1;          // two products summed
   localparam int RotW  = ProdW - RotShift;         // rotated component
   localparam int SqW   = 2 * RotW - 2;             // ay^2 + az^2, unsigned
   localparam int RootW = SqW / 2;
   localparam int RemW  = RootW + 2;
   localparam int SqSteps = RootW;

   localparam int XW      = RotW + 2;               // CORDIC x/y with gain headroom
   localparam int IntFrac = 24;
   localparam int ZW      = IntFrac + 10;           // degrees * 2^24, sign, headroom
   localparam int OutShift = IntFrac - AngleFracBits;

   localparam logic signed [ZW-1:0] HalfTurnInt = ZW'(180) <<< IntFrac;
   localparam logic signed [ZW-1:0] RoundHalf   = ZW'(1) <<< (OutShift - 1);
   localparam logic signed [ZW-1:0] HalfTurnOut = ZW'(180) <<< AngleFracBits;
   localparam logic signed [ZW-1:0] FullTurnOut = ZW'(360) <<< AngleFracBits;

   // atan(2^-i) in degrees * 2^24, rounded
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = ZW'(754974720);
         1:  v = ZW'(445687602);
         2:  v = ZW'(235489088);
         3:  v = ZW'(119537938);
         4:  v = ZW'(59000934);
         5:  v = ZW'(30029717);
         6:  v = ZW'(15018523);
         7:  v = ZW'(7509720);
         8:  v = ZW'(3754917);
         9:  v = ZW'(1877466);
         10: v = ZW'(938734);
         11: v = ZW'(469367);
         12: v = ZW'(234684);
         13: v = ZW'(117342);
         14: v = ZW'(58671);
         15: v = ZW'(29335);
         16: v = ZW'(14668);
         17: v = ZW'(7334);
         18: v = ZW'(3667);
         19: v = ZW'(1833);
         20: v = ZW'(917);
         21: v = ZW'(458);
         22: v = ZW'(229);
         23: v = ZW'(115);
         default: v = '0;
      endcase
      return v;
   endfunction

   // low SampleBits bits, sign extended
   function automatic logic signed [SampleW-1:0] sample_value(input logic [SampleW-1:0] raw);
      logic [SampleW-1:0] up;
      up = raw << (SampleW - SampleBits);
      return $signed(up) >>> (SampleW - SampleBits);
   endfunction

   function automatic logic signed [ZW-1:0] clamp_half(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] r;
      if (v > HalfTurnOut) begin
         r = HalfTurnOut;
      end else if (v < -HalfTurnOut) begin
         r = -HalfTurnOut;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/attitude_from_accel_mag.sv */
// Top level: roll, pitch and yaw from one accelerometer and one magnetometer word.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: accel x,y,z, mag x,y,z (16b each)
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: roll, pitch, yaw (16b); tuser: invalid
//
// One word enters per cycle while rsp is not stalled. Stages: rotate, square, sum,
// one square-root bit per stage, CORDIC setup, one CORDIC iteration per stage for
// all three angles, then fold/wrap.
// Reset clears the valid bits only. A stalled rsp freezes the whole pipeline;
// req_tready falls in the same cycle, so nothing is dropped or repeated.
module attitude_from_accel_mag (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_angle, pitch_angle, yaw_angle
   output logic        rsp_tuser    // sample_invalid
);

   localparam int SW  = afam_pkg::SampleW;
   localparam int RW  = afam_pkg::RotW;
   localparam int PW  = afam_pkg::ProdW;
   localparam int QW  = afam_pkg::SqW;
   localparam int TW  = afam_pkg::RootW;
   localparam int MW  = afam_pkg::RemW;
   localparam int NQ  = afam_pkg::SqSteps;
   localparam int XW  = afam_pkg::XW;
   localparam int ZW  = afam_pkg::ZW;
   localparam int NC  = afam_pkg::StageCount;
   localparam int AW  = afam_pkg::AngleW;

   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: sign extend, invalid check, mounting rotation
   logic signed [SW-1:0] smp [0:5];
   logic signed [RW-1:0] rot_in [0:5];
   logic                 inv_in;
   logic signed [RW-1:0] rot_ff [0:5];
   logic                 inv1_ff, vld1_ff;

   always_comb begin
      logic signed [PW-1:0] e [0:5];
      logic signed [PW-1:0] sa, sb;
      for (int k = 0; k < 6; k++) begin
         smp[k] = afam_pkg::sample_value(req_tdata[SW*k +: SW]);
         e[k]   = PW'(smp[k]);
      end
      inv_in = (smp[0] == '0 && smp[1] == '0 && smp[2] == '0) ||
               (smp[3] == '0 && smp[4] == '0 && smp[5] == '0);
      for (int v = 0; v < 2; v++) begin
         sa = e[3*v] * PW'(afam_pkg::MountC);
         sb = e[3*v+1] * PW'(afam_pkg::MountC);
         rot_in[3*v]   = RW'((sa + sb) >>> afam_pkg::RotShift);
         rot_in[3*v+1] = RW'((sa - sb) >>> afam_pkg::RotShift);
         rot_in[3*v+2] = RW'((e[3*v+2] * PW'(afam_pkg::MountNeg)) >>> afam_pkg::RotShift);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff  <= rot_in;
         inv1_ff <= inv_in;
      end
   end

   // ---------------- stage 2: squares of ay', az'
   logic [QW-1:0]        sqy_ff, sqz_ff;
   logic signed [RW-1:0] rot2_ff [0:5];
   logic                 inv2_ff, vld2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqy_ff  <= QW'(rot_ff[1] * rot_ff[1]);
         sqz_ff  <= QW'(rot_ff[2] * rot_ff[2]);
         rot2_ff <= rot_ff;
         inv2_ff <= inv1_ff;
      end
   end

   // ---------------- stage 3 + square root, one result bit per stage
   logic [QW-1:0]        sq_n_ff    [0:NQ];
   logic [MW-1:0]        sq_rem_ff  [0:NQ];
   logic [TW-1:0]        sq_root_ff [0:NQ];
   logic signed [RW-1:0] sq_rot_ff  [0:NQ][0:5];
   logic [NQ:0]          sq_inv_ff;
   logic [NQ:0]          sq_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0]    <= sqy_ff + sqz_ff;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_rot_ff[0]  <= rot2_ff;
         sq_inv_ff[0]  <= inv2_ff;
      end
   end

   for (genvar k = 0; k < NQ; k++) begin : g_sqrt
      logic [MW-1:0] rem_in;
      logic [TW-1:0] root_in;
      always_comb begin
         logic [MW-1:0] cur, trial;
         cur   = {sq_rem_ff[k][MW-3:0], sq_n_ff[k][QW-1 -: 2]};
         trial = {sq_root_ff[k], 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {sq_root_ff[k][TW-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {sq_root_ff[k][TW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_n_ff[k+1]    <= sq_n_ff[k] << 2;
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
            sq_rot_ff[k+1]  <= sq_rot_ff[k];
            sq_inv_ff[k+1]  <= sq_inv_ff[k];
         end
      end
   end

   // ---------------- CORDIC setup: lanes 0 roll, 1 pitch, 2 yaw
   logic signed [XW-1:0] cx_ff [0:NC][0:2];
   logic signed [XW-1:0] cy_ff [0:NC][0:2];
   logic signed [ZW-1:0] cz_ff [0:NC][0:2];
   logic [2:0]           czero_ff [0:NC];
   logic [NC:0]          caz_neg_ff, cax_neg_ff, cinv_ff, cvld_ff;

   logic signed [XW-1:0] px_in [0:2];
   logic signed [XW-1:0] py_in [0:2];
   logic signed [ZW-1:0] pz_in [0:2];
   logic [2:0]           pzero_in;

   always_comb begin
      logic signed [XW-1:0] xs [0:2];
      logic signed [XW-1:0] ys [0:2];
      xs[0] = XW'(sq_rot_ff[NQ][2]);
      ys[0] = XW'(sq_rot_ff[NQ][1]);
      xs[1] = $signed({{(XW-TW){1'b0}}, sq_root_ff[NQ]});
      ys[1] = XW'(sq_rot_ff[NQ][0]);
      xs[2] = XW'(sq_rot_ff[NQ][3]);
      ys[2] = XW'(sq_rot_ff[NQ][4]);
      for (int l = 0; l < 3; l++) begin
         pzero_in[l] = (xs[l] == '0) && (ys[l] == '0);
         if (xs[l] < 0) begin
            px_in[l] = -xs[l];
            py_in[l] = -ys[l];
            pz_in[l] = (ys[l] >= 0) ? afam_pkg::HalfTurnInt : -afam_pkg::HalfTurnInt;
         end else begin
            px_in[l] = xs[l];
            py_in[l] = ys[l];
            pz_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]      <= px_in;
         cy_ff[0]      <= py_in;
         cz_ff[0]      <= pz_in;
         czero_ff[0]   <= pzero_in;
         caz_neg_ff[0] <= sq_rot_ff[NQ][2] < 0;
         cax_neg_ff[0] <= sq_rot_ff[NQ][0] < 0;
         cinv_ff[0]    <= sq_inv_ff[NQ];
      end
   end

   // ---------------- CORDIC vectoring, one iteration per stage
   for (genvar i = 0; i < NC; i++) begin : g_cordic
      logic signed [XW-1:0] x_in [0:2];
      logic signed [XW-1:0] y_in [0:2];
      logic signed [ZW-1:0] z_in [0:2];
      always_comb begin
         logic signed [XW-1:0] dx, dy;
         for (int l = 0; l < 3; l++) begin
            dx = cy_ff[i][l] >>> i;
            dy = cx_ff[i][l] >>> i;
            if (cy_ff[i][l] < 0) begin
               x_in[l] = cx_ff[i][l] - dx;
               y_in[l] = cy_ff[i][l] + dy;
               z_in[l] = cz_ff[i][l] - afam_pkg::atan_entry(i);
            end else begin
               x_in[l] = cx_ff[i][l] + dx;
               y_in[l] = cy_ff[i][l] - dy;
               z_in[l] = cz_ff[i][l] + afam_pkg::atan_entry(i);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]      <= x_in;
            cy_ff[i+1]      <= y_in;
            cz_ff[i+1]      <= z_in;
            czero_ff[i+1]   <= czero_ff[i];
            caz_neg_ff[i+1] <= caz_neg_ff[i];
            cax_neg_ff[i+1] <= cax_neg_ff[i];
            cinv_ff[i+1]    <= cinv_ff[i];
         end
      end
   end

   // ---------------- output: round, clamp, pitch fold, yaw wrap
   logic [AW-1:0] roll_in, pitch_in, yaw_in;
   logic [AW-1:0] roll_ff, pitch_ff, yaw_ff;
   logic          inv_out_ff;

   always_comb begin
      logic signed [ZW-1:0] a [0:2];
      logic signed [ZW-1:0] p, y;
      for (int l = 0; l < 3; l++) begin
         a[l] = afam_pkg::clamp_half((cz_ff[NC][l] + afam_pkg::RoundHalf)
                                     >>> afam_pkg::OutShift);
         if (czero_ff[NC][l]) begin
            a[l] = '0;
         end
      end
      p = a[1];
      if (caz_neg_ff[NC]) begin
         p = cax_neg_ff[NC] ? (-afam_pkg::HalfTurnOut - a[1])
                            : (afam_pkg::HalfTurnOut - a[1]);
         p = afam_pkg::clamp_half(p);
      end
      y = (a[2] < 0) ? (a[2] + afam_pkg::FullTurnOut) : a[2];
      if (cinv_ff[NC]) begin
         roll_in  = '0;
         pitch_in = '0;
         yaw_in   = '0;
      end else begin
         roll_in  = a[0][AW-1:0];
         pitch_in = p[AW-1:0];
         yaw_in   = y[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff    <= roll_in;
         pitch_ff   <= pitch_in;
         yaw_ff     <= yaw_in;
         inv_out_ff <= cinv_ff[NC];
      end
   end

   // ---------------- valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         sq_vld_ff    <= '0;
         cvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld1_ff      <= req_tvalid;
         vld2_ff      <= vld1_ff;
         sq_vld_ff    <= {sq_vld_ff[NQ-1:0], vld2_ff};
         cvld_ff      <= {cvld_ff[NC-1:0], sq_vld_ff[NQ]};
         rsp_valid_ff <= cvld_ff[NC];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = inv_out_ff;

endmodule

/* tb/tb.sv */
// Testbench for attitude_from_accel_mag: directed and random words checked by a local predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AngFrac   = 7;
   localparam int Stages    = 16;
   localparam int FracInt   = 24;
   localparam int ShiftOut  = FracInt - AngFrac;
   localparam longint Half  = 64'sd180 << AngFrac;
   localparam longint Full  = 64'sd360 << AngFrac;
   localparam int Latency   = 45;
   localparam int WatchLim  = 2000;
   localparam int NumRandom = 2000;

   typedef struct packed {
      logic        invalid;
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
   } attitude_type;

   // atan(2^-i), degrees * 2^24
   localparam longint AtanDeg [24] = '{
      754974720, 445687602, 235489088, 119537938, 59000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   int errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic longint vec_angle(input longint y, input longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? (64'sd180 << FracInt) : -(64'sd180 << FracInt);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x -= dx; y += dy; z -= AtanDeg[i];
         end else begin
            x += dx; y -= dy; z += AtanDeg[i];
         end
      end
      z = (z + (64'sd1 <<< (ShiftOut - 1))) >>> ShiftOut;
      if (z > Half) z = Half;
      if (z < -Half) z = -Half;
      return z;
   endfunction

   function automatic longint int_sqrt(input longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic attitude_type predict_attitude(input logic [95:0] word);
      longint a[3], m[3], ra[3], rm[3];
      longint roll, pitch, yaw, r;
      attitude_type o;
      for (int k = 0; k < 3; k++) begin
         a[k] = longint'($signed(word[16*k +: 16]));
         m[k] = longint'($signed(word[48 + 16*k +: 16]));
      end
      o.invalid = (a[0] == 0 && a[1] == 0 && a[2] == 0) ||
                  (m[0] == 0 && m[1] == 0 && m[2] == 0);
      roll = 0; pitch = 0; yaw = 0;
      if (!o.invalid) begin
         // mounting: (c,c,0), (c,-c,0), (0,0,-1)
         ra[0] = (23170 * a[0] + 23170 * a[1]) >>> 8;
         ra[1] = (23170 * a[0] - 23170 * a[1]) >>> 8;
         ra[2] = (-32768 * a[2]) >>> 8;
         rm[0] = (23170 * m[0] + 23170 * m[1]) >>> 8;
         rm[1] = (23170 * m[0] - 23170 * m[1]) >>> 8;
         roll = vec_angle(ra[1], ra[2]);
         r = int_sqrt(ra[1] * ra[1] + ra[2] * ra[2]);
         pitch = vec_angle(ra[0], r);
         if (ra[2] < 0) begin
            pitch = (ra[0] >= 0) ? Half - pitch : -Half - pitch;
            if (pitch > Half) pitch = Half;
            if (pitch < -Half) pitch = -Half;
         end
         yaw = vec_angle(rm[1], rm[0]);
         if (yaw < 0) yaw += Full;
      end
      o.roll = roll[15:0];
      o.pitch = pitch[15:0];
      o.yaw = yaw[15:0];
      return o;
   endfunction

   class attitude_board;
      attitude_type pending[$];
      function void note_sample(input logic [95:0] word);
         pending.push_back(predict_attitude(word));
      endfunction
      task check_result(input logic [47:0] data, input logic flag);
         attitude_type w;
         if (pending.size() == 0) begin
            report("unexpected word", data, 0);
            return;
         end
         w = pending.pop_front();
         if (data[15:0] !== w.roll)
            report("roll", $signed(data[15:0]), $signed(w.roll));
         if (data[31:16] !== w.pitch)
            report("pitch", $signed(data[31:16]), $signed(w.pitch));
         if (data[47:32] !== w.yaw) report("yaw", data[47:32], w.yaw);
         if (flag !== w.invalid) report("invalid", flag, w.invalid);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   attitude_board board = new();
   int  accepted = 0, checked = 0, idle = 0;
   bit  no_gaps = 0;

   attitude_from_accel_mag dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle <= 0;
      end else begin
         idle <= idle + 1;
         if (idle >= WatchLim) begin
            $display("watchdog: no progress for %0d cycles", idle);
            $display("tb: errors");
            $finish;
         end
      end
   end

   // scoreboard taps, both sides
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_sample(req_tdata);
         accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser);
         checked++;
      end
   end

   // result side: random back-pressure before each word
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         repeat (gap) begin
            rsp_tready <= 0;
            @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // one word on req, after a random gap; tvalid stays high across back-to-back words
   task automatic send_word(input logic [95:0] word);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [95:0] pick_word();
      logic [95:0] w;
      for (int k = 0; k < 6; k++) w[16*k +: 16] = pick_axis();
      // occasionally zero a whole vector to hit the invalid flag
      case ($urandom_range(0, 19))
         0: w[47:0] = '0;
         1: w[95:48] = '0;
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [95:0] dir[$];
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      dir.push_back({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});         // both vectors zero
      dir.push_back({16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd0});       // accel zero
      dir.push_back({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});         // mag zero
      dir.push_back({16'd50, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000});     // yaw undefined
      dir.push_back({16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1});         // roll undefined
      dir.push_back({48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff});
      dir.push_back({48'h8000_8000_8000, 48'h8000_8000_8000});
      dir.push_back({48'h7fff_8000_7fff, 48'h8000_7fff_8000});
      dir.push_back({48'h0001_0000_ffff, 48'h0000_ffff_0001});
      dir.push_back({48'h0000_0001_0000, 48'h0001_0000_0000});
      dir.push_back({48'h0000_ffff_0000, 48'h0000_0000_ffff});
      dir.push_back({48'h0000_0000_1000, 48'h7fff_7fff_7fff});           // az' < 0, fold
      dir.push_back({48'h0000_0000_f000, 48'h8000_7fff_7fff});           // az' > 0
      dir.push_back({48'h0000_0000_1000, 48'h8000_8000_8000});           // az' > 0, ax' < 0
      dir.push_back({48'h0000_0000_0001, 48'h0000_0000_7fff});           // az' = 0, ax' > 0
      dir.push_back({48'hffff_0000_0001, 48'h0000_0001_ffff});
      foreach (dir[i]) send_word(dir[i]);

      // random; one stretch without any idling
      for (int n = 0; n < NumRandom; n++) begin
         no_gaps = (n >= 800 && n < 1100);
         send_word(pick_word());
      end
      no_gaps = 0;
      req_tvalid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (rsp_tvalid) report("extra word", rsp_tdata, 0);

      $display("covered %0d sample words, %0d attitude words checked", accepted, checked);
      $display("includes zero vectors, undefined directions, full-scale axes, fold cases");
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
